@@ rtl/bfo_pkg.sv @@
package bfo_pkg;

  // Queue geometry: DEPTH cells, one always left free, so DEPTH-1 bytes are held.
  localparam int unsigned DEPTH = 256;
  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned OCC_W = 8;
  // Wide enough for both the pointer difference and the reported occupancy.
  localparam int unsigned WIDE_W = (PTR_W > OCC_W) ? PTR_W : OCC_W;

  // Request kinds.
  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_READ  = 1'b1;

  // Full-queue write policies; the unused code behaves like refuse.
  localparam logic [1:0] POLICY_REFUSE    = 2'd0;
  localparam logic [1:0] POLICY_DROP      = 2'd1;
  localparam logic [1:0] POLICY_OVERWRITE = 2'd2;

  // Status codes.
  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_BLOCK = 1'b1;

  // One request into the queue.
  typedef struct packed {
    logic       req_type;
    logic [7:0] write_data;
    logic       last_byte;
  } bfo_req_t;

  // One response out of the queue.
  typedef struct packed {
    logic       [7:0] read_data;
    logic             status;
    logic             accepted;
    logic [OCC_W-1:0] occupancy;
    logic             readable;
    logic             writable;
    logic             reader_wakeup;
    logic             writer_wakeup;
    logic             end_of_request;
  } bfo_rsp_t;

endpackage

@@ rtl/byte_fifo_overflow_policy_top.sv @@
// Circular byte queue with a programmable policy for writes into a full queue.
// Request channel: a request (write one byte or read one byte) is taken at each
// rising edge where start_i is high and busy_o is low. busy_o stays low, so a
// request can be issued in every cycle.
// Response channel: every request yields one response, shown on rsp_o for
// exactly one cycle with rsp_valid_o high, in the cycle after the request was
// taken. The receiver cannot stall it, and none is needed: the pointers
// and the byte store are updated at the accepting edge, and the read byte
// comes from the registered read port of the store in the following cycle.
// Throughput is one request per cycle, set by the pointer update at each
// accepting edge and the one write and one read port of the store.
// Configuration: cfg_valid_i / cfg_ready_o write the full policy register
// (0 refuse, 1 drop, 2 overwrite oldest); cfg_ready_o is always high. Write it
// only while no request is in flight.
// Reset: the pointers clear (queue empty), the policy goes to refuse and no
// response is pending. The byte store itself is not cleared.
module byte_fifo_overflow_policy_top (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  bfo_pkg::bfo_req_t req_i,
  output logic              rsp_valid_o,
  output bfo_pkg::bfo_rsp_t rsp_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [1:0]        cfg_data_i
);
  import bfo_pkg::*;

  localparam logic [PTR_W-1:0] LAST_IDX = PTR_W'(DEPTH - 1);

  logic [PTR_W-1:0] head_q, head_d;
  logic [PTR_W-1:0] tail_q, tail_d;
  logic [1:0]       policy_q;

  logic [7:0] store_q [DEPTH];
  logic [7:0] rdata_q;

  logic accept;
  logic is_read;
  logic was_empty, prior_full;
  logic now_empty, now_full;
  logic mem_we, mem_re;
  logic status_d, accepted_d, rwake_d, wwake_d;
  logic [PTR_W-1:0] head_inc, tail_inc, tail_d_inc;
  logic [PTR_W:0]   diff_wide;
  logic [WIDE_W-1:0] occ_wide;

  // Response register.
  logic             rsp_valid_q;
  logic             rd_hit_q;
  logic             status_q, accepted_q, rwake_q, wwake_q, last_q;
  logic             readable_q, writable_q;
  logic [OCC_W-1:0] occ_q;

  function automatic logic [PTR_W-1:0] next_idx(input logic [PTR_W-1:0] p);
    return (p == LAST_IDX) ? '0 : p + PTR_W'(1);
  endfunction

  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign accept      = start_i && !busy_o;
  assign is_read     = (req_i.req_type == REQ_READ);

  // Queue state before the request.
  assign head_inc   = next_idx(head_q);
  assign tail_inc   = next_idx(tail_q);
  assign was_empty  = (head_q == tail_q);
  assign prior_full = (tail_inc == head_q);

  // Pointer update and per-request flags.
  always_comb begin
    head_d     = head_q;
    tail_d     = tail_q;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    status_d   = STATUS_OK;
    accepted_d = 1'b0;
    wwake_d    = 1'b0;
    if (accept) begin
      if (!is_read) begin
        if (!prior_full) begin
          tail_d     = tail_inc;
          mem_we     = 1'b1;
          accepted_d = 1'b1;
        end else begin
          case (policy_q)
            POLICY_DROP: begin
              accepted_d = 1'b1;
            end
            POLICY_OVERWRITE: begin
              head_d     = head_inc;
              tail_d     = tail_inc;
              mem_we     = 1'b1;
              accepted_d = 1'b1;
            end
            default: begin
              status_d = STATUS_BLOCK;
            end
          endcase
        end
      end else begin
        if (was_empty) begin
          status_d = STATUS_BLOCK;
        end else begin
          head_d     = head_inc;
          mem_re     = 1'b1;
          accepted_d = 1'b1;
          wwake_d    = prior_full;
        end
      end
    end
  end

  // Queue state after the request.
  assign tail_d_inc = next_idx(tail_d);
  assign now_empty  = (head_d == tail_d);
  assign now_full   = (tail_d_inc == head_d);
  assign rwake_d    = !is_read && was_empty && !now_empty;

  // Occupancy, modulo DEPTH, reported in its low eight bits.
  always_comb begin
    if (tail_d >= head_d) begin
      diff_wide = {1'b0, tail_d} - {1'b0, head_d};
    end else begin
      diff_wide = {1'b0, tail_d} + (PTR_W + 1)'(DEPTH) - {1'b0, head_d};
    end
    occ_wide = WIDE_W'(diff_wide[PTR_W-1:0]);
  end

  // Control state: pointers, policy and response strobe.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      tail_q      <= '0;
      policy_q    <= POLICY_REFUSE;
      rsp_valid_q <= 1'b0;
    end else begin
      head_q      <= head_d;
      tail_q      <= tail_d;
      rsp_valid_q <= accept;
      if (cfg_valid_i && cfg_ready_o) begin
        policy_q <= cfg_data_i;
      end
    end
  end

  // Response fields, captured with the request.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      rd_hit_q   <= mem_re;
      status_q   <= status_d;
      accepted_q <= accepted_d;
      rwake_q    <= rwake_d;
      wwake_q    <= wwake_d;
      last_q     <= req_i.last_byte;
      readable_q <= !now_empty;
      writable_q <= !now_full;
      occ_q      <= occ_wide[OCC_W-1:0];
    end
  end

  // Byte store: one write port at the tail, one registered read port at the head.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      store_q[tail_q] <= req_i.write_data;
    end
    if (mem_re) begin
      rdata_q <= store_q[head_q];
    end
  end

  // Response outputs.
  assign rsp_valid_o          = rsp_valid_q;
  assign rsp_o.read_data      = rd_hit_q ? rdata_q : 8'h00;
  assign rsp_o.status         = status_q;
  assign rsp_o.accepted       = accepted_q;
  assign rsp_o.occupancy      = occ_q;
  assign rsp_o.readable       = readable_q;
  assign rsp_o.writable       = writable_q;
  assign rsp_o.reader_wakeup  = rwake_q;
  assign rsp_o.writer_wakeup  = wwake_q;
  assign rsp_o.end_of_request = last_q;

endmodule
